// ===== sv/c1d_pkg.sv =====
// Shared types and fixed-point constants for the 1D convolution engine.
// No dependencies; imported by c1d_store and conv1d_mac_engine.
`timescale 1ns / 1ps

package c1d_pkg;

  localparam int DATA_W = 16;   // Q3.12 samples, weights, biases and results
  localparam int ADDR_W = 15;   // width of the request address field
  localparam int FRAC   = 12;   // fraction bits of the data format
  // The accumulator covers 256 channels times 16 taps of full-scale products plus the bias.
  localparam int ACC_W  = 48;
  localparam int RND_W  = ACC_W - FRAC;
  localparam int POS_W  = 12;   // signed sample position, room for 1024 samples plus taps
  localparam int ROUND_HALF = 1 << (FRAC - 1);
  localparam int SAT_MAX = 32767;
  localparam int SAT_MIN = -32768;

  // One enable per store, for writes and for reads.
  typedef struct packed {
    logic weight;
    logic bias;
    logic sample;
  } c1d_store_en_t;

endpackage

// ===== sv/c1d_store.sv =====
// Weight, bias and sample memories of the convolution engine.
// One write port and one registered read port per memory; uses c1d_pkg.
`timescale 1ns / 1ps

module c1d_store #(
  parameter int W_DEPTH = 32768,
  parameter int B_DEPTH = 64,
  parameter int X_DEPTH = 8192,
  localparam int WAW = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1,
  localparam int BAW = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1,
  localparam int XAW = (X_DEPTH > 1) ? $clog2(X_DEPTH) : 1
) (
  input  logic                              clk,
  input  c1d_pkg::c1d_store_en_t            wr_en,
  input  logic [c1d_pkg::ADDR_W-1:0]        wr_addr,
  input  logic signed [c1d_pkg::DATA_W-1:0] wr_data,
  input  c1d_pkg::c1d_store_en_t            rd_en,
  input  logic [WAW-1:0]                    w_raddr,
  input  logic [BAW-1:0]                    b_raddr,
  input  logic [XAW-1:0]                    x_raddr,
  output logic signed [c1d_pkg::DATA_W-1:0] w_q,
  output logic signed [c1d_pkg::DATA_W-1:0] b_q,
  output logic signed [c1d_pkg::DATA_W-1:0] x_q
);
  import c1d_pkg::*;

  logic signed [DATA_W-1:0] weight_mem [W_DEPTH];
  logic signed [DATA_W-1:0] bias_mem   [B_DEPTH];
  logic signed [DATA_W-1:0] sample_mem [X_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en.weight) begin
      weight_mem[WAW'(wr_addr)] <= wr_data;
    end
    if (rd_en.weight) begin
      w_q <= weight_mem[w_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en.bias) begin
      bias_mem[BAW'(wr_addr)] <= wr_data;
    end
    if (rd_en.bias) begin
      b_q <= bias_mem[b_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en.sample) begin
      sample_mem[XAW'(wr_addr)] <= wr_data;
    end
    if (rd_en.sample) begin
      x_q <= sample_mem[x_raddr];
    end
  end

endmodule

// ===== sv/conv1d_mac_engine.sv =====
// Multi-channel strided, zero-padded 1D convolution with one shared MAC.
// Top level; uses c1d_pkg and c1d_store.
//
// Requests arrive on the in_ stream. tuser carries the kind: weight, bias or
// sample write, or compute. A write is taken while the block is idle and gives no result.
// A compute request names an output channel and position; its result leaves on
// the out_ stream with the value in Q3.12, the echoed channel and position,
// and the status and saturation flags in tuser.
// A compute passes from acceptance through the setup, base, multiply-accumulate,
// drain and round states to the result register; the single multiply-accumulate
// unit takes one weight and one sample per cycle, behind a registered memory read
// and a registered product. An out-of-range request goes from setup to done.
// in_tready is low while a compute is in progress, so no other request is taken
// until its result enters the result register; writes stream at one per cycle.
// The result register holds one finished result: writes are taken while it
// waits, and a following compute finishes its arithmetic and then waits until
// out_tready empties the register.
// The user must write registers on the cfg_ channel only while the block is idle;
// the block does not enforce it. Reset restores the register defaults and empties
// the pipeline; the memories keep whatever they held and must be loaded before use.
`timescale 1ns / 1ps

module conv1d_mac_engine #(
  parameter int MAX_IN_CH  = 64,
  parameter int MAX_OUT_CH = 64,
  parameter int MAX_KERNEL = 8,
  parameter int MAX_LENGTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: address[14:0], value[30:15], out_channel[36:31], out_position[43:37], zero
  input  logic [47:0] in_tdata,
  // in_tuser: kind[1:0]
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: result_value[15:0], result_channel[21:16], result_position[28:22], zero
  output logic [31:0] out_tdata,
  // out_tuser: status[0], saturated[1]
  output logic [1:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import c1d_pkg::*;

  localparam int W_DEPTH = MAX_OUT_CH * MAX_IN_CH * MAX_KERNEL;
  localparam int B_DEPTH = MAX_OUT_CH;
  localparam int X_DEPTH = MAX_IN_CH * MAX_LENGTH;
  localparam int WAW = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
  localparam int BAW = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam int XAW = (X_DEPTH > 1) ? $clog2(X_DEPTH) : 1;
  localparam int CW  = (MAX_IN_CH > 1) ? $clog2(MAX_IN_CH) : 1;
  localparam int KW  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int CCW = $clog2(MAX_IN_CH + 1);
  localparam int OCW = $clog2(MAX_OUT_CH + 1);
  localparam int KCW = $clog2(MAX_KERNEL + 1);
  localparam int LCW = $clog2(MAX_LENGTH + 1);

  localparam logic [1:0] KIND_WEIGHT  = 2'd0;
  localparam logic [1:0] KIND_BIAS    = 2'd1;
  localparam logic [1:0] KIND_SAMPLE  = 2'd2;
  localparam logic [1:0] KIND_COMPUTE = 2'd3;

  localparam logic [2:0] CFG_LENGTH  = 3'd0;
  localparam logic [2:0] CFG_IN_CH   = 3'd1;
  localparam logic [2:0] CFG_OUT_CH  = 3'd2;
  localparam logic [2:0] CFG_KERNEL  = 3'd3;
  localparam logic [2:0] CFG_STRIDE  = 3'd4;
  localparam logic [2:0] CFG_PADDING = 3'd5;
  localparam logic [2:0] CFG_BIAS_EN = 3'd6;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_BASE  = 3'd2;
  localparam logic [2:0] S_MAC   = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_ROUND = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  // Request fields
  logic [1:0]               in_kind;
  logic [ADDR_W-1:0]        in_addr;
  logic signed [DATA_W-1:0] in_value;
  logic [5:0]               in_oc;
  logic [6:0]               in_pos;
  logic                     in_fire;

  assign in_kind  = in_tuser;
  assign in_addr  = in_tdata[14:0];
  assign in_value = $signed(in_tdata[30:15]);
  assign in_oc    = in_tdata[36:31];
  assign in_pos   = in_tdata[43:37];
  assign in_fire  = in_tvalid && in_tready;

  // Configuration registers
  logic [7:0] cfg_len_r;
  logic [6:0] cfg_ich_r;
  logic [6:0] cfg_och_r;
  logic [3:0] cfg_k_r;
  logic [2:0] cfg_s_r;
  logic [2:0] cfg_pad_r;
  logic       cfg_bias_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r  <= 8'd128;
      cfg_ich_r  <= 7'd1;
      cfg_och_r  <= 7'd1;
      cfg_k_r    <= 4'd1;
      cfg_s_r    <= 3'd1;
      cfg_pad_r  <= 3'd0;
      cfg_bias_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LENGTH:  cfg_len_r  <= cfg_data;
        CFG_IN_CH:   cfg_ich_r  <= cfg_data[6:0];
        CFG_OUT_CH:  cfg_och_r  <= cfg_data[6:0];
        CFG_KERNEL:  cfg_k_r    <= cfg_data[3:0];
        CFG_STRIDE:  cfg_s_r    <= cfg_data[2:0];
        CFG_PADDING: cfg_pad_r  <= cfg_data[2:0];
        CFG_BIAS_EN: cfg_bias_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Registers clamped to their legal ranges
  logic [LCW-1:0] lc;
  logic [CCW-1:0] cc;
  logic [OCW-1:0] occ;
  logic [KCW-1:0] kc;
  logic [2:0]     sc;

  always_comb begin
    if (cfg_len_r == 8'd0) begin
      lc = LCW'(1);
    end else if (int'(cfg_len_r) > MAX_LENGTH) begin
      lc = LCW'(MAX_LENGTH);
    end else begin
      lc = LCW'(cfg_len_r);
    end
    if (cfg_ich_r == 7'd0) begin
      cc = CCW'(1);
    end else if (int'(cfg_ich_r) > MAX_IN_CH) begin
      cc = CCW'(MAX_IN_CH);
    end else begin
      cc = CCW'(cfg_ich_r);
    end
    if (cfg_och_r == 7'd0) begin
      occ = OCW'(1);
    end else if (int'(cfg_och_r) > MAX_OUT_CH) begin
      occ = OCW'(MAX_OUT_CH);
    end else begin
      occ = OCW'(cfg_och_r);
    end
    if (cfg_k_r == 4'd0) begin
      kc = KCW'(1);
    end else if (int'(cfg_k_r) > MAX_KERNEL) begin
      kc = KCW'(MAX_KERNEL);
    end else begin
      kc = KCW'(cfg_k_r);
    end
    if (cfg_s_r == 3'd0) begin
      sc = 3'd1;
    end else if (cfg_s_r > 3'd4) begin
      sc = 3'd4;
    end else begin
      sc = cfg_s_r;
    end
  end

  // Sequencer state and datapath registers
  logic [2:0]               state_r, state_nxt;
  logic [5:0]               oc_r;
  logic [6:0]               t_r;
  logic                     status_r;
  logic [WAW-1:0]           occ_prod_r;
  logic [WAW-1:0]           widx_r;
  logic [XAW-1:0]           xrow_r;
  logic signed [POS_W-1:0]  pos_base_r;
  logic [CW-1:0]            ic_r;
  logic [KW-1:0]            k_r;
  logic                     drain_r;
  logic                     v1_r, v2_r;
  logic signed [31:0]       prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [RND_W-1:0]  rnd_r;

  // Output register
  logic                     out_valid_r;
  logic [DATA_W-1:0]        out_value_r;
  logic [5:0]               out_ch_r;
  logic [6:0]               out_pos_r;
  logic                     out_status_r;
  logic                     out_sat_r;

  // Range check of a compute request: position t is valid when t*S <= L + 2P - K.
  logic signed [POS_W-1:0]  span_s, ts_s, pos_s;
  logic                     req_bad;
  logic                     tap_ok;
  logic                     last_k, last_ic;
  logic                     out_load;

  always_comb begin
    span_s  = POS_W'(lc) + POS_W'(cfg_pad_r) + POS_W'(cfg_pad_r) - POS_W'(kc);
    ts_s    = POS_W'(t_r) * POS_W'(sc);
    req_bad = (int'(oc_r) >= int'(occ)) || (span_s < 0) || (ts_s > span_s);
    pos_s   = pos_base_r + POS_W'(k_r);
    tap_ok  = !pos_s[POS_W-1] && ($unsigned(pos_s) < POS_W'(lc));
    last_k  = (KCW'(k_r) + KCW'(1)) == kc;
    last_ic = (CCW'(ic_r) + CCW'(1)) == cc;
  end

  assign in_tready = (state_r == S_IDLE);
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // Store access
  c1d_store_en_t            wr_en, rd_en;
  logic [WAW-1:0]           w_raddr;
  logic [BAW-1:0]           b_raddr;
  logic [XAW-1:0]           x_raddr;
  logic signed [DATA_W-1:0] w_q, b_q, x_q;

  always_comb begin
    wr_en.weight = in_fire && (in_kind == KIND_WEIGHT) && (int'(in_addr) < W_DEPTH);
    wr_en.bias   = in_fire && (in_kind == KIND_BIAS)   && (int'(in_addr) < B_DEPTH);
    wr_en.sample = in_fire && (in_kind == KIND_SAMPLE) && (int'(in_addr) < X_DEPTH);
    rd_en.weight = (state_r == S_MAC);
    rd_en.bias   = (state_r == S_SETUP);
    rd_en.sample = (state_r == S_MAC) && tap_ok;
    w_raddr      = widx_r;
    b_raddr      = BAW'(oc_r);
    x_raddr      = xrow_r + XAW'($unsigned(pos_s));
  end

  c1d_store #(
    .W_DEPTH(W_DEPTH),
    .B_DEPTH(B_DEPTH),
    .X_DEPTH(X_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_addr),
    .wr_data (in_value),
    .rd_en   (rd_en),
    .w_raddr (w_raddr),
    .b_raddr (b_raddr),
    .x_raddr (x_raddr),
    .w_q     (w_q),
    .b_q     (b_q),
    .x_q     (x_q)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire && (in_kind == KIND_COMPUTE)) state_nxt = S_SETUP;
      S_SETUP: state_nxt = req_bad ? S_DONE : S_BASE;
      S_BASE:  state_nxt = S_MAC;
      S_MAC:   if (last_k && last_ic) state_nxt = S_DRAIN;
      S_DRAIN: if (drain_r) state_nxt = S_ROUND;
      S_ROUND: state_nxt = S_DONE;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      drain_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= rd_en.sample;
      v2_r    <= v1_r;
      drain_r <= (state_r == S_DRAIN) && !drain_r;
    end
  end

  logic signed [ACC_W-1:0] rnd_sum;
  assign rnd_sum = acc_r + ACC_W'(ROUND_HALF);

  always_ff @(posedge clk) begin
    prod_r <= 32'(w_q) * 32'(x_q);
    case (state_r)
      S_IDLE: begin
        oc_r <= in_oc;
        t_r  <= in_pos;
      end
      S_SETUP: begin
        status_r   <= req_bad;
        occ_prod_r <= WAW'(oc_r) * WAW'(cc);
        pos_base_r <= ts_s - POS_W'(cfg_pad_r);
      end
      S_BASE: begin
        widx_r <= occ_prod_r * WAW'(kc);
        xrow_r <= '0;
        ic_r   <= '0;
        k_r    <= '0;
        acc_r  <= cfg_bias_r ? (ACC_W'(b_q) <<< FRAC) : '0;
      end
      S_MAC: begin
        widx_r <= widx_r + WAW'(1);
        if (last_k) begin
          k_r    <= '0;
          ic_r   <= ic_r + CW'(1);
          xrow_r <= xrow_r + XAW'(lc);
        end else begin
          k_r <= k_r + KW'(1);
        end
      end
      S_ROUND: begin
        rnd_r <= RND_W'(rnd_sum >>> FRAC);
      end
      default: begin
      end
    endcase
    // The last products land here during the drain cycles.
    if (v2_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // Saturation and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch_r     <= oc_r;
      out_pos_r    <= t_r;
      out_status_r <= status_r;
      if (status_r) begin
        out_value_r <= '0;
        out_sat_r   <= 1'b0;
      end else if (rnd_r > RND_W'(SAT_MAX)) begin
        out_value_r <= DATA_W'(SAT_MAX);
        out_sat_r   <= 1'b1;
      end else if (rnd_r < RND_W'(SAT_MIN)) begin
        out_value_r <= DATA_W'(SAT_MIN);
        out_sat_r   <= 1'b1;
      end else begin
        out_value_r <= rnd_r[DATA_W-1:0];
        out_sat_r   <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_pos_r, out_ch_r, out_value_r};
  assign out_tuser  = {out_sat_r, out_status_r};

`ifndef ASSERT_OFF
  // A result only appears when the sequencer finishes a request.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result appeared without a finished request");

  // A rejected request carries a zero value and no saturation flag.
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> ((out_value_r == '0) && !out_sat_r))
    else $error("rejected request carries a value");

  // A saturated result sits at one of the two range limits.
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sat_r) |->
      ((out_value_r == 16'h7FFF) || (out_value_r == 16'h8000)))
    else $error("saturated result is not at a limit");

  // No product is in flight outside the accumulation and drain phases; checked here while idle.
  a_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!v1_r && !v2_r))
    else $error("product in flight while idle");
`endif

endmodule
